// ----- rtl/core/dbhc_pkg.sv -----
// Package for the DNA base Hamming codec: transaction types, status codes,
// register indexes and the Hamming(7,4) and base-character helper functions.
// No dependencies.
package dbhc_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int QUEUE_DEPTH_DEFAULT = 2;
  localparam int WORD_W = 14;

  localparam logic [CFG_INDEX_W-1:0] REG_CODING_MODE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION   = 2'd1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_LENGTH  = 2'd2;

  localparam logic MODE_PLAIN   = 1'b0;
  localparam logic MODE_HAMMING = 1'b1;
  localparam logic DIR_ENCODE   = 1'b0;
  localparam logic DIR_DECODE   = 1'b1;

  localparam logic [2:0] PLAIN_BASES   = 3'd4;
  localparam logic [2:0] HAMMING_BASES = 3'd7;

  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_T = 8'h54;
  localparam logic [7:0] CHAR_C = 8'h43;
  localparam logic [7:0] CHAR_G = 8'h47;

  typedef struct packed {
    logic [7:0] in_value;
    logic       final_item;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_value;
    logic       run_last;
    logic [1:0] status;
    logic       corrected;
  } out_item_t;

  // One queue entry: a run of bases to send, or one finished result.
  typedef struct packed {
    logic              is_run;
    logic [WORD_W-1:0] word;
    logic [2:0]        nbases;
    logic [1:0]        status;
    logic              corrected;
  } cmd_t;

  function automatic logic [6:0] hamming_encode4(input logic [3:0] d);
    logic p1, p2, p3;
    p1 = d[3] ^ d[2] ^ d[0];
    p2 = d[3] ^ d[1] ^ d[0];
    p3 = d[2] ^ d[1] ^ d[0];
    return {p1, p2, d[3], p3, d[2], d[1], d[0]};
  endfunction

  // Returns {fixed, nibble}.
  function automatic logic [4:0] hamming_decode7(input logic [6:0] cw_in);
    logic [6:0] cw;
    logic [2:0] syn;
    logic [2:0] pos;
    cw  = cw_in;
    syn = {cw[3] ^ cw[2] ^ cw[1] ^ cw[0],
           cw[5] ^ cw[4] ^ cw[1] ^ cw[0],
           cw[6] ^ cw[4] ^ cw[2] ^ cw[0]};
    pos = 3'd7 - syn;
    if (syn != 3'd0) begin
      cw[pos] = ~cw[pos];
    end
    return {(syn != 3'd0), cw[4], cw[2], cw[1], cw[0]};
  endfunction

  function automatic logic [7:0] base_char(input logic [1:0] b);
    logic [7:0] c;
    case (b)
      2'd0:    c = CHAR_A;
      2'd1:    c = CHAR_T;
      2'd2:    c = CHAR_C;
      default: c = CHAR_G;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/core/dbhc_front.sv -----
// Front end of the codec: configuration registers, input acceptance, base
// gathering and classification into queue commands. Depends on dbhc_pkg.
module dbhc_front import dbhc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic                   cfg_data,
  input  logic                   q_full,
  output logic                   push,
  output cmd_t                   push_cmd
);

  logic              coding_mode;
  logic              direction;
  logic [WORD_W-1:0] gathered_bits;
  logic [2:0]        bases_gathered;
  logic              skipping;

  logic [WORD_W-1:0] gathered_next;
  logic [2:0]        bases_next;
  logic              skipping_next;
  logic              accept;
  logic [1:0]        bval;
  logic              bad_char;
  logic [WORD_W-1:0] gathered_inc;
  logic [2:0]        bases_inc;
  logic [2:0]        group;
  logic [4:0]        dec_hi;
  logic [4:0]        dec_lo;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;

  always_comb begin
    bad_char = 1'b0;
    case (in_data.in_value)
      CHAR_A:  bval = 2'd0;
      CHAR_T:  bval = 2'd1;
      CHAR_C:  bval = 2'd2;
      CHAR_G:  bval = 2'd3;
      default: begin
        bval     = 2'd0;
        bad_char = 1'b1;
      end
    endcase
  end

  assign gathered_inc = {gathered_bits[WORD_W-3:0], bval};
  assign bases_inc    = bases_gathered + 3'd1;
  assign group        = (coding_mode == MODE_HAMMING) ? HAMMING_BASES : PLAIN_BASES;
  assign dec_hi       = hamming_decode7(gathered_inc[13:7]);
  assign dec_lo       = hamming_decode7(gathered_inc[6:0]);

  always_comb begin
    gathered_next = gathered_bits;
    bases_next    = bases_gathered;
    skipping_next = skipping;
    push          = 1'b0;
    push_cmd      = '0;
    push_cmd.nbases = 3'd1;
    if (accept) begin
      if (skipping) begin
        if (in_data.final_item) begin
          skipping_next = 1'b0;
          gathered_next = '0;
          bases_next    = '0;
        end
      end else if (direction == DIR_ENCODE) begin
        push            = 1'b1;
        push_cmd.is_run = 1'b1;
        push_cmd.status = STATUS_OK;
        if (coding_mode == MODE_HAMMING) begin
          push_cmd.word   = {hamming_encode4(in_data.in_value[7:4]),
                             hamming_encode4(in_data.in_value[3:0])};
          push_cmd.nbases = HAMMING_BASES;
        end else begin
          push_cmd.word   = {6'd0, in_data.in_value};
          push_cmd.nbases = PLAIN_BASES;
        end
      end else if (bad_char) begin
        push            = 1'b1;
        push_cmd.status = STATUS_INVALID;
        gathered_next   = '0;
        bases_next      = '0;
        skipping_next   = !in_data.final_item;
      end else if (bases_inc >= group) begin
        push          = 1'b1;
        gathered_next = '0;
        bases_next    = '0;
        push_cmd.status = STATUS_OK;
        if (coding_mode == MODE_HAMMING) begin
          push_cmd.word      = {6'd0, dec_hi[3:0], dec_lo[3:0]};
          push_cmd.corrected = dec_hi[4] | dec_lo[4];
        end else begin
          push_cmd.word = {6'd0, gathered_inc[7:0]};
        end
      end else if (in_data.final_item) begin
        push            = 1'b1;
        push_cmd.status = STATUS_LENGTH;
        gathered_next   = '0;
        bases_next      = '0;
      end else begin
        gathered_next = gathered_inc;
        bases_next    = bases_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coding_mode    <= MODE_PLAIN;
      direction      <= DIR_ENCODE;
      gathered_bits  <= '0;
      bases_gathered <= '0;
      skipping       <= 1'b0;
    end else if (cfg_valid && cfg_ready &&
                 (cfg_index == REG_CODING_MODE || cfg_index == REG_DIRECTION)) begin
      if (cfg_index == REG_CODING_MODE) begin
        coding_mode <= cfg_data;
      end else begin
        direction <= cfg_data;
      end
      gathered_bits  <= '0;
      bases_gathered <= '0;
      skipping       <= 1'b0;
    end else begin
      gathered_bits  <= gathered_next;
      bases_gathered <= bases_next;
      skipping       <= skipping_next;
    end
  end

endmodule

// ----- rtl/core/dbhc_queue.sv -----
// Short command queue between the front and back ends of the codec.
// Depends on dbhc_pkg for the command type.
module dbhc_queue import dbhc_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output cmd_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/core/dbhc_back.sv -----
// Back end of the codec: expands queue commands into result transactions, one base
// or byte per cycle when not stalled, into the output register. Depends on dbhc_pkg.
module dbhc_back import dbhc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  cmd_t      head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic [2:0] pos;
  logic [2:0] sel;
  logic [3:0] shift;
  logic       load;
  logic       last_step;
  out_item_t  next_item;

  assign load      = head_valid && (!out_valid || !out_stall);
  assign last_step = !head.is_run || (pos == head.nbases - 3'd1);
  assign pop       = load && last_step;
  assign sel       = head.nbases - 3'd1 - pos;
  assign shift     = {sel, 1'b0};

  always_comb begin
    next_item.run_last  = last_step;
    next_item.status    = head.status;
    next_item.corrected = head.corrected;
    if (head.is_run) begin
      next_item.out_value = base_char(head.word[shift +: 2]);
    end else begin
      next_item.out_value = head.word[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= next_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      pos       <= last_step ? 3'd0 : pos + 3'd1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ----- rtl/core/dna_base_hamming_codec_unit.sv -----
// DNA base codec with Hamming(7,4) option: bytes to A/T/C/G characters and back.
// A result passes through the command queue and then the output register.
// The result port sends one transaction per cycle while out_stall is low;
// encoding sends 4 characters per byte (plain) or 7 (Hamming), one per base.
// Reset clears the mode registers (plain encode), the gathered group, the
// command queue and the output valid flag.
module dna_base_hamming_codec_unit import dbhc_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic                   cfg_data
);

  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic head_valid;
  cmd_t head;

  dbhc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  dbhc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (q_full),
    .head_valid(head_valid),
    .head      (head)
  );

  dbhc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for dna_base_hamming_codec_unit: a directed table, then random
// byte and base-character traffic in all four mode/direction settings, checked against a predictor.
// Depends on dbhc_pkg and the codec RTL.
module testbench;
  import dbhc_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam logic [31:0] BASE_CHARS = {CHAR_G, CHAR_C, CHAR_T, CHAR_A};
  localparam int SETTLE_CYCLES = 10;
  localparam int RANDOM_ITEMS = 175;
  localparam int QUIET_AFTER = 145;

  typedef struct packed {
    logic      use_fixed;
    out_item_t res;
  } row_fix_t;

  typedef struct packed {
    logic                   is_cfg;
    logic [CFG_INDEX_W-1:0] idx;
    logic                   cdata;
    logic [7:0]             val;
    logic                   fin;
    logic                   use_fixed;
    out_item_t              res;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic cfg_data = 1'b0;

  logic cur_mode = MODE_PLAIN;
  logic cur_dir = DIR_ENCODE;
  logic [13:0] gather_bits = '0;
  logic [2:0] gather_cnt = '0;
  logic drop_to_final = 1'b0;

  out_item_t codec_out_q[$];
  out_item_t step_outs[$];
  row_fix_t row_fix_q[$];
  plan_row_t plan[$];
  int mismatches = 0;
  bit quiet = 1'b0;
  int stall_left = 0;

  dna_base_hamming_codec_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic out_item_t mk_out(logic [7:0] v, logic l, logic [1:0] s, logic c);
    out_item_t o;
    o.out_value = v;
    o.run_last  = l;
    o.status    = s;
    o.corrected = c;
    return o;
  endfunction

  function automatic logic [7:0] char_of_base(logic [1:0] b);
    return BASE_CHARS[8*b +: 8];
  endfunction

  // {invalid, base}
  function automatic logic [2:0] base_of_char(logic [7:0] c);
    logic [2:0] r;
    int q;
    r = 3'b100;
    for (q = 0; q < 4; q++) begin
      if (BASE_CHARS[8*q +: 8] == c) begin
        r = {1'b0, q[1:0]};
      end
    end
    return r;
  endfunction

  function automatic logic [6:0] ham_pack(logic [3:0] d);
    logic p1, p2, p3;
    p1 = d[3] ^ d[2] ^ d[0];
    p2 = d[3] ^ d[1] ^ d[0];
    p3 = d[2] ^ d[1] ^ d[0];
    return {p1, p2, d[3], p3, d[2], d[1], d[0]};
  endfunction

  // {fixed, nibble}
  function automatic logic [4:0] ham_fix(logic [6:0] cw);
    logic [6:0] c;
    logic [2:0] syn;
    c = cw;
    syn[0] = c[6] ^ c[4] ^ c[2] ^ c[0];
    syn[1] = c[5] ^ c[4] ^ c[1] ^ c[0];
    syn[2] = c[3] ^ c[2] ^ c[1] ^ c[0];
    if (syn != 3'd0) begin
      c = c ^ (7'd1 << (7 - int'(syn)));
    end
    return {syn != 3'd0, c[4], c[2], c[1], c[0]};
  endfunction

  function automatic void clear_group();
    gather_bits = '0;
    gather_cnt = '0;
  endfunction

  function automatic void model_config(logic [CFG_INDEX_W-1:0] idx, logic d);
    if (idx == REG_CODING_MODE) begin
      cur_mode = d;
    end else if (idx == REG_DIRECTION) begin
      cur_dir = d;
    end else begin
      return;
    end
    drop_to_final = 1'b0;
    clear_group();
  endfunction

  function automatic void codec_predict(in_item_t it);
    logic [13:0] w;
    int n;
    int k;
    logic [2:0] bv;
    logic [2:0] grp;
    logic [4:0] hi, lo;
    step_outs.delete();
    if (drop_to_final) begin
      if (it.final_item) begin
        drop_to_final = 1'b0;
        clear_group();
      end
      return;
    end
    if (cur_dir == DIR_ENCODE) begin
      if (cur_mode == MODE_PLAIN) begin
        w = {6'd0, it.in_value};
        n = 4;
      end else begin
        w = {ham_pack(it.in_value[7:4]), ham_pack(it.in_value[3:0])};
        n = 7;
      end
      for (k = n - 1; k >= 0; k--) begin
        step_outs = {step_outs, mk_out(char_of_base(w[2*k +: 2]), k == 0, STATUS_OK, 1'b0)};
      end
      return;
    end
    bv = base_of_char(it.in_value);
    if (bv[2]) begin
      step_outs = {step_outs, mk_out(8'h00, 1'b1, STATUS_INVALID, 1'b0)};
      clear_group();
      drop_to_final = !it.final_item;
      return;
    end
    gather_bits = {gather_bits[11:0], bv[1:0]};
    gather_cnt = gather_cnt + 3'd1;
    grp = (cur_mode == MODE_PLAIN) ? PLAIN_BASES : HAMMING_BASES;
    if (gather_cnt >= grp) begin
      if (cur_mode == MODE_PLAIN) begin
        step_outs = {step_outs, mk_out(gather_bits[7:0], 1'b1, STATUS_OK, 1'b0)};
      end else begin
        hi = ham_fix(gather_bits[13:7]);
        lo = ham_fix(gather_bits[6:0]);
        step_outs = {step_outs, mk_out({hi[3:0], lo[3:0]}, 1'b1, STATUS_OK, hi[4] | lo[4])};
      end
      clear_group();
    end else if (it.final_item) begin
      clear_group();
      step_outs = {step_outs, mk_out(8'h00, 1'b1, STATUS_LENGTH, 1'b0)};
    end
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    row_fix_t fix;
    out_item_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        model_config(cfg_index, cfg_data);
      end
      if (in_valid && !in_stall) begin
        fix = row_fix_q.pop_front();
        codec_predict(in_data);
        if (fix.use_fixed) begin
          codec_out_q = {codec_out_q, fix.res};
        end else begin
          codec_out_q = {codec_out_q, step_outs};
        end
      end
      if (out_valid && !out_stall) begin
        if (codec_out_q.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual %h", $time, out_data);
          mismatches++;
        end else begin
          want = codec_out_q.pop_front();
          check_field("out_value", want.out_value, out_data.out_value);
          check_field("run_last", 8'(want.run_last), 8'(out_data.run_last));
          check_field("status", 8'(want.status), 8'(out_data.status));
          check_field("corrected", 8'(want.corrected), 8'(out_data.corrected));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) begin
        out_stall <= 1'b0;
      end
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(1, 14);
    end
  end

  task automatic send(logic [7:0] v, logic f, logic use_fixed, out_item_t res);
    row_fix_t fix;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    fix.use_fixed = use_fixed;
    fix.res = res;
    row_fix_q = {row_fix_q, fix};
    in_valid <= 1'b1;
    in_data <= {v, f};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_base(logic [1:0] b, logic f);
    send(char_of_base(b), f, 1'b0, '0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (codec_out_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic d);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void add_cfg(logic [CFG_INDEX_W-1:0] idx, logic d);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.cdata = d;
    plan = {plan, r};
  endfunction

  function automatic void add_item(logic [7:0] v, logic f, logic use_fixed, out_item_t res);
    plan_row_t r;
    r = '0;
    r.val = v;
    r.fin = f;
    r.use_fixed = use_fixed;
    r.res = res;
    plan = {plan, r};
  endfunction

  initial begin
    int items, j, k, n, phase_len, p, pick, waited;
    logic m, d, held;
    logic [7:0] b;
    logic [13:0] w;
    out_item_t bad_char, short_len;
    bad_char = mk_out(8'h00, 1'b1, STATUS_INVALID, 1'b0);
    short_len = mk_out(8'h00, 1'b1, STATUS_LENGTH, 1'b0);

    add_item(8'h00, 1'b0, 1'b0, '0);
    add_item(8'hFF, 1'b1, 1'b0, '0);
    add_cfg(REG_CODING_MODE, MODE_HAMMING);
    add_item(8'h00, 1'b0, 1'b0, '0);
    add_item(8'hFF, 1'b1, 1'b0, '0);
    add_cfg(REG_DIRECTION, DIR_DECODE);
    repeat (6) add_item(CHAR_G, 1'b0, 1'b0, '0);
    add_item(CHAR_G, 1'b0, 1'b1, mk_out(8'hFF, 1'b1, STATUS_OK, 1'b0));
    add_item(CHAR_A, 1'b0, 1'b0, '0);
    add_item(8'h78, 1'b0, 1'b1, bad_char);
    add_item(CHAR_G, 1'b0, 1'b0, '0);
    add_item(CHAR_A, 1'b1, 1'b0, '0);
    add_cfg(REG_SPARE_3, 1'b1);
    add_item(CHAR_T, 1'b1, 1'b1, short_len);
    add_cfg(REG_CODING_MODE, MODE_PLAIN);
    add_item(CHAR_T, 1'b0, 1'b0, '0);
    add_item(CHAR_C, 1'b0, 1'b0, '0);
    add_item(CHAR_G, 1'b0, 1'b0, '0);
    add_item(CHAR_A, 1'b1, 1'b0, '0);
    add_item(CHAR_C, 1'b0, 1'b0, '0);
    add_item(CHAR_A, 1'b1, 1'b1, short_len);
    add_item(8'h00, 1'b1, 1'b1, bad_char);
    add_item(8'hFF, 1'b0, 1'b1, bad_char);
    add_item(CHAR_G, 1'b1, 1'b0, '0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_reg(plan[i].idx, plan[i].cdata);
      end else begin
        send(plan[i].val, plan[i].fin, plan[i].use_fixed, plan[i].res);
      end
    end

    items = 0;
    p = 0;
    held = 1'b0;
    while (items < RANDOM_ITEMS) begin
      quiet = (items >= QUIET_AFTER);
      m = (p < 4) ? p[0] : 1'($urandom_range(0, 1));
      d = (p < 4) ? p[1] : 1'($urandom_range(0, 1));
      if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_CODING_MODE, m);
        write_reg(REG_DIRECTION, d);
      end else begin
        write_reg(REG_DIRECTION, d);
        write_reg(REG_CODING_MODE, m);
      end
      if ($urandom_range(0, 3) == 0) begin
        write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, 1'($urandom_range(0, 1)));
      end
      n = (m == MODE_PLAIN) ? 4 : 7;
      phase_len = $urandom_range(12, 30);
      j = 0;
      while (j < phase_len) begin
        if (p >= 5 && j >= 6 && !held) begin
          drain();
          held = 1'b1;
        end
        if (d == DIR_ENCODE) begin
          send(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b0, '0);
          j++;
        end else begin
          pick = $urandom_range(0, 7);
          if (pick < 6) begin
            b = 8'($urandom_range(0, 255));
            if (m == MODE_PLAIN) begin
              w = {6'd0, b};
            end else begin
              w = {ham_pack(b[7:4]), ham_pack(b[3:0])};
              if ($urandom_range(0, 1) == 0) w[$urandom_range(0, 13)] ^= 1'b1;
              if ($urandom_range(0, 7) == 0) w[$urandom_range(0, 13)] ^= 1'b1;
            end
            for (k = n - 1; k >= 0; k--) begin
              send_base(w[2*k +: 2], k == 0 && $urandom_range(0, 3) == 0);
            end
            j += n;
          end else if (pick == 6) begin
            k = $urandom_range(1, n - 1);
            repeat (k - 1) send_base(2'($urandom_range(0, 3)), 1'b0);
            send_base(2'($urandom_range(0, 3)), 1'b1);
            j += k;
          end else begin
            b = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 1) == 0) begin
              send(b, 1'b1, 1'b0, '0);
              j++;
            end else begin
              send(b, 1'b0, 1'b0, '0);
              send_base(2'($urandom_range(0, 3)), 1'b0);
              send_base(2'($urandom_range(0, 3)), 1'b0);
              send(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
              j += 4;
            end
          end
        end
      end
      items += j;
      p++;
    end

    quiet = 1'b1;
    in_valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (codec_out_q.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (codec_out_q.size() != 0) begin
      $display("%0t: results missing, expected %0d more, actual 0", $time, codec_out_q.size());
      $display("testbench: FAIL");
      $finish;
    end else begin
      repeat (20) @(posedge clk);
      if (mismatches == 0) begin
        $display("testbench: PASS");
      end else begin
        $display("testbench: FAIL");
      end
      $finish;
    end
  end

  initial begin
    #3000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
